// File: src/linear_blend_skinning_assert.svh
// Assertion macros shared by the checker of the skinning block.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// Checked only outside reset.
`define LBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("linear_blend_skinning check failed");

// Checked at every edge, reset included.
`define LBS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("linear_blend_skinning reset check failed");

`endif

// File: src/lbs_pkg.sv
// Shared constants, types and fixed-point helpers of the skinning block.
// No dependencies.
package lbs_pkg;

  localparam int MAX_JOINTS  = 64;
  localparam int INFLUENCES  = 4;
  localparam int FRAC_BITS   = 16;
  localparam int MAT_WORDS   = 12;
  localparam int WEIGHT_BITS = 16;
  localparam int BONE_W      = 6;
  localparam int JOINT_W     = 6;
  localparam int ELEM_W      = 4;
  localparam int NSTAGE      = 9;
  localparam int RND_W       = 64 - FRAC_BITS;
  localparam int WPROD_W     = 32 + WEIGHT_BITS + 1;
  localparam int WRND_W      = WPROD_W - WEIGHT_BITS;

  typedef enum logic [1:0] {
    OP_LOAD_POSE = 2'd0,
    OP_LOAD_BIND = 2'd1,
    OP_BUILD     = 2'd2,
    OP_SKIN      = 2'd3
  } op_t;

  localparam logic REG_JOINT_COUNT = 1'b0;
  localparam logic REG_IDENTITY    = 1'b1;

  typedef logic [31:0] word_t;
  typedef word_t [MAT_WORDS-1:0] mat_t;
  typedef word_t [2:0] vec3_t;
  typedef logic [63:0] prod_t;
  typedef logic [WPROD_W-1:0] wprod_t;

  // Round half up to the fraction width: add half an LSB, then floor.
  function automatic logic signed [RND_W-1:0] round_frac(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + (64'sd1 <<< (FRAC_BITS - 1));
    return s[63:FRAC_BITS];
  endfunction

  function automatic logic signed [WRND_W-1:0] round_weight(
      input logic signed [WPROD_W-1:0] p);
    logic signed [WPROD_W-1:0] s;
    s = p + (WPROD_W'(1) <<< (WEIGHT_BITS - 1));
    return s[WPROD_W-1:WEIGHT_BITS];
  endfunction

  function automatic word_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

// File: src/linear_blend_skinning.sv
// Linear blend skinning, four influences, Q16.16: nine-stage pipeline.
// A request accepted at the input moves through stage registers 0 to 8 in turn.
// Throughput: one request per cycle while out_stall is low; every stage holds
// one request and the stall chain is set by the output register alone.
// Reset (rst_n, synchronous, low) clears valid bits and configuration registers;
// the pose, bind and palette memories keep their content and need no clearing pass.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_joint_index,
  input  logic [3:0]         in_element_index,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_nrm_x,
  input  logic signed [31:0] in_nrm_y,
  input  logic signed [31:0] in_nrm_z,
  input  logic [23:0]        in_bone_ids,
  input  logic [63:0]        in_bone_weights,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_nrm_x,
  output logic signed [31:0] out_nrm_y,
  output logic signed [31:0] out_nrm_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [6:0] joint_count_r;
  logic       identity_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= '0;
      identity_r    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_JOINT_COUNT: joint_count_r <= pwdata[6:0];
        REG_IDENTITY:    identity_r    <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_JOINT_COUNT: prdata = {25'd0, joint_count_r};
      REG_IDENTITY:    prdata = {31'd0, identity_r};
      default:         prdata = '0;
    endcase
  end

  // Pipeline control: a stage loads when it is empty or its content moves on.
  logic [NSTAGE-1:0] v_r, v_nxt, ready;

  always_comb begin
    ready[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ready[k] = !v_r[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = v_r[NSTAGE-1];

  // Stage registers.
  op_t                    op0_r, op1_r, op2_r, op3_r, op4_r, op5_r, op6_r, op7_r;
  logic [JOINT_W-1:0]     joint0_r, joint1_r, joint2_r, joint3_r;
  logic [ELEM_W-1:0]      elem0_r;
  word_t                  load0_r;
  vec3_t                  pos0_r, pos1_r, pos2_r, pos3_r, pos4_r;
  vec3_t                  nrm0_r, nrm1_r, nrm2_r, nrm3_r, nrm4_r;
  logic [23:0]            bones0_r, bones1_r, bones2_r, bones3_r;
  logic [63:0]            wts0_r, wts1_r, wts2_r, wts3_r, wts4_r, wts5_r, wts6_r;
  logic [INFLUENCES-1:0]  mask1_r, mask2_r, mask3_r, mask4_r, mask5_r, mask6_r, mask7_r;
  logic [INFLUENCES-1:0]  mask1_nxt;
  mat_t                   pose1_r, bind1_r;
  prod_t [MAT_WORDS-1:0][2:0] bprod2_r, bprod2_nxt;
  vec3_t                  trans2_r;
  mat_t                   pal3_r, pal3_nxt;
  mat_t [INFLUENCES-1:0]  palrd4_r;
  prod_t [INFLUENCES-1:0][2:0][5:0] sprod5_r, sprod5_nxt;
  vec3_t [INFLUENCES-1:0] trans5_r;
  word_t [INFLUENCES-1:0][5:0] tv6_r, tv6_nxt;
  wprod_t [INFLUENCES-1:0][5:0] wprod7_r, wprod7_nxt;
  word_t [5:0]            res8_r, res8_nxt;

  // Memories.
  word_t pose_mem [MAT_WORDS][MAX_JOINTS];
  word_t bind_mem [MAT_WORDS][MAX_JOINTS];
  mat_t  pal_mem  [INFLUENCES][MAX_JOINTS];

  logic load_we, pal_we;

  assign load_we = v_r[0] && ready[1] && (op0_r == OP_LOAD_POSE || op0_r == OP_LOAD_BIND)
                   && (int'(joint0_r) < MAX_JOINTS) && (int'(elem0_r) < MAT_WORDS);
  assign pal_we  = v_r[3] && ready[4] && (op3_r == OP_BUILD) && (int'(joint3_r) < MAX_JOINTS);

  always_comb begin
    v_nxt[0] = ready[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTAGE - 1; k++) begin
      v_nxt[k] = ready[k] ? v_r[k-1] : v_r[k];
    end
    // Only skin requests leave a result.
    v_nxt[NSTAGE-1] = ready[NSTAGE-1] ? (v_r[NSTAGE-2] && op7_r == OP_SKIN)
                                      : v_r[NSTAGE-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: input capture.
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      op0_r    <= op_t'(in_opcode);
      joint0_r <= in_joint_index;
      elem0_r  <= in_element_index;
      load0_r  <= in_load_value;
      pos0_r   <= {in_pos_z, in_pos_y, in_pos_x};
      nrm0_r   <= {in_nrm_z, in_nrm_y, in_nrm_x};
      bones0_r <= in_bone_ids;
      wts0_r   <= in_bone_weights;
    end
  end

  // Stage 1: pose and bind reads, element loads, influence mask.
  always_comb begin
    for (int i = 0; i < INFLUENCES; i++) begin
      mask1_nxt[i] = (wts0_r[WEIGHT_BITS*i +: WEIGHT_BITS] != '0)
                     && ({1'b0, bones0_r[BONE_W*i +: BONE_W]} < joint_count_r)
                     && (int'(bones0_r[BONE_W*i +: BONE_W]) < MAX_JOINTS);
    end
  end

  always_ff @(posedge clk) begin
    if (load_we && op0_r == OP_LOAD_POSE) begin
      pose_mem[elem0_r][joint0_r] <= load0_r;
    end
    if (load_we && op0_r == OP_LOAD_BIND) begin
      bind_mem[elem0_r][joint0_r] <= load0_r;
    end
    if (ready[1]) begin
      for (int e = 0; e < MAT_WORDS; e++) begin
        pose1_r[e] <= pose_mem[e][joint0_r];
        bind1_r[e] <= bind_mem[e][joint0_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      op1_r    <= op0_r;
      joint1_r <= joint0_r;
      pos1_r   <= pos0_r;
      nrm1_r   <= nrm0_r;
      bones1_r <= bones0_r;
      wts1_r   <= wts0_r;
      mask1_r  <= mask1_nxt;
    end
  end

  // Stage 2: pose times bind products.
  always_comb begin
    logic signed [31:0] a, b;
    logic signed [63:0] p;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 3; k++) begin
          a = signed'(pose1_r[r*4+k]);
          b = signed'(bind1_r[k*4+c]);
          p = a * b;
          bprod2_nxt[r*4+c][k] = p;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      op2_r    <= op1_r;
      joint2_r <= joint1_r;
      bprod2_r <= bprod2_nxt;
      trans2_r <= {pose1_r[11], pose1_r[7], pose1_r[3]};
      pos2_r   <= pos1_r;
      nrm2_r   <= nrm1_r;
      bones2_r <= bones1_r;
      wts2_r   <= wts1_r;
      mask2_r  <= mask1_r;
    end
  end

  // Stage 3: round, sum and saturate the palette words, or the identity matrix in identity mode.
  always_comb begin
    logic signed [63:0] s;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        s = 64'(round_frac(signed'(bprod2_r[r*4+c][0])))
          + 64'(round_frac(signed'(bprod2_r[r*4+c][1])))
          + 64'(round_frac(signed'(bprod2_r[r*4+c][2])));
        if (c == 3) begin
          s = s + 64'(signed'(trans2_r[r]));
        end
        if (identity_r) begin
          pal3_nxt[r*4+c] = (r == c) ? (32'd1 << FRAC_BITS) : 32'd0;
        end else begin
          pal3_nxt[r*4+c] = sat32(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      op3_r    <= op2_r;
      joint3_r <= joint2_r;
      pal3_r   <= pal3_nxt;
      pos3_r   <= pos2_r;
      nrm3_r   <= nrm2_r;
      bones3_r <= bones2_r;
      wts3_r   <= wts2_r;
      mask3_r  <= mask2_r;
    end
  end

  // Stage 4: palette write for builds, one read per influence for skins.
  // A build writes here in the same stage where later skins read, so a skin
  // always sees every build ahead of it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < INFLUENCES; i++) begin
      if (pal_we) begin
        pal_mem[i][joint3_r] <= pal3_r;
      end
      if (ready[4]) begin
        palrd4_r[i] <= pal_mem[i][bones3_r[BONE_W*i +: BONE_W]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      op4_r   <= op3_r;
      pos4_r  <= pos3_r;
      nrm4_r  <= nrm3_r;
      wts4_r  <= wts3_r;
      mask4_r <= mask3_r;
    end
  end

  // Stage 5: palette times position and normal.
  always_comb begin
    logic signed [31:0] m, x, n;
    logic signed [63:0] pp, pn;
    for (int i = 0; i < INFLUENCES; i++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          m  = signed'(palrd4_r[i][r*4+k]);
          x  = signed'(pos4_r[k]);
          n  = signed'(nrm4_r[k]);
          pp = m * x;
          pn = m * n;
          sprod5_nxt[i][r][k]   = pp;
          sprod5_nxt[i][r][3+k] = pn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      op5_r    <= op4_r;
      sprod5_r <= sprod5_nxt;
      for (int i = 0; i < INFLUENCES; i++) begin
        trans5_r[i] <= {palrd4_r[i][11], palrd4_r[i][7], palrd4_r[i][3]};
      end
      wts5_r  <= wts4_r;
      mask5_r <= mask4_r;
    end
  end

  // Stage 6: per-influence transformed components.
  always_comb begin
    logic signed [63:0] sp, sn;
    for (int i = 0; i < INFLUENCES; i++) begin
      for (int r = 0; r < 3; r++) begin
        sp = 64'(round_frac(signed'(sprod5_r[i][r][0])))
           + 64'(round_frac(signed'(sprod5_r[i][r][1])))
           + 64'(round_frac(signed'(sprod5_r[i][r][2])))
           + 64'(signed'(trans5_r[i][r]));
        sn = 64'(round_frac(signed'(sprod5_r[i][r][3])))
           + 64'(round_frac(signed'(sprod5_r[i][r][4])))
           + 64'(round_frac(signed'(sprod5_r[i][r][5])));
        tv6_nxt[i][r]   = sat32(sp);
        tv6_nxt[i][3+r] = sat32(sn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      op6_r   <= op5_r;
      tv6_r   <= tv6_nxt;
      wts6_r  <= wts5_r;
      mask6_r <= mask5_r;
    end
  end

  // Stage 7: weight products.
  always_comb begin
    logic signed [31:0] t;
    logic signed [WEIGHT_BITS:0] w;
    logic signed [WPROD_W-1:0] p;
    for (int i = 0; i < INFLUENCES; i++) begin
      w = signed'({1'b0, wts6_r[WEIGHT_BITS*i +: WEIGHT_BITS]});
      for (int j = 0; j < 6; j++) begin
        t = signed'(tv6_r[i][j]);
        p = t * w;
        wprod7_nxt[i][j] = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      op7_r    <= op6_r;
      wprod7_r <= wprod7_nxt;
      mask7_r  <= mask6_r;
    end
  end

  // Stage 8: blend the taken influences and saturate.
  always_comb begin
    logic signed [63:0] acc;
    for (int j = 0; j < 6; j++) begin
      acc = '0;
      for (int i = 0; i < INFLUENCES; i++) begin
        if (mask7_r[i]) begin
          acc = acc + 64'(round_weight(signed'(wprod7_r[i][j])));
        end
      end
      res8_nxt[j] = sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[8]) begin
      res8_r <= res8_nxt;
    end
  end

  assign out_pos_x = signed'(res8_r[0]);
  assign out_pos_y = signed'(res8_r[1]);
  assign out_pos_z = signed'(res8_r[2]);
  assign out_nrm_x = signed'(res8_r[3]);
  assign out_nrm_y = signed'(res8_r[4]);
  assign out_nrm_z = signed'(res8_r[5]);

endmodule

// File: src/lbs_checker.sv
// Port-level checks of the skinning block, bound to its top level.
// Depends on linear_blend_skinning_assert.svh.
`include "linear_blend_skinning_assert.svh"

module lbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pos_x,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // The input side only stalls when every stage is full behind a held result.
  `LBS_ASSERT(a_stall_needs_full, in_stall |-> (out_valid && out_stall))
  `LBS_ASSERT(a_out_held, (out_valid && out_stall) |=> (out_valid && $stable(out_pos_x)))
  `LBS_ASSERT(a_count_readback, (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]) |-> (prdata[6:0] == $past(pwdata[6:0])))
  `LBS_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for linear_blend_skinning: random and directed requests,
// a cycle-free prediction of the skinned vertex, and APB register setup.
// Depends on lbs_pkg and the linear_blend_skinning RTL.
module tb_top;
  import lbs_pkg::*;

  typedef struct {
    op_t         opcode;
    logic [5:0]  joint;
    logic [3:0]  elem;
    logic [31:0] value;
    logic [31:0] pos [3];
    logic [31:0] nrm [3];
    logic [23:0] bones;
    logic [63:0] weights;
  } request_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] nrm [3];
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_pos [3];
  logic [31:0] out_nrm [3];
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  request_t cur;
  request_t pending_q [$];
  vertex_t  vertex_q [$];
  int errors = 0;
  int gap_left = 0, stall_left = 0;
  logic took = 1'b0;
  logic send_quiet = 1'b0, recv_quiet = 1'b0;
  int results_seen = 0;
  string pos_names [3] = '{"out_pos_x", "out_pos_y", "out_pos_z"};
  string nrm_names [3] = '{"out_nrm_x", "out_nrm_y", "out_nrm_z"};

  // Predictor state: the block's memories and registers.
  logic [31:0] pose_mem [MAX_JOINTS*MAT_WORDS];
  logic [31:0] bind_mem [MAX_JOINTS*MAT_WORDS];
  logic [31:0] pal_mem  [MAX_JOINTS*MAT_WORDS];
  int unsigned joints_used = 0;
  logic ident = 1'b0;

  // Stimulus-side record of what has been written, so no unwritten entry is read.
  bit pose_w [MAX_JOINTS][MAT_WORDS];
  bit bind_w [MAX_JOINTS][MAT_WORDS];
  bit pal_ok [MAX_JOINTS];

  initial begin
    cur.opcode = OP_LOAD_POSE; cur.joint = '0; cur.elem = '0; cur.value = '0;
    cur.bones = '0; cur.weights = '0;
    for (int k = 0; k < 3; k++) begin
      cur.pos[k] = '0; cur.nrm[k] = '0;
    end
  end

  initial begin
    forever #4 clk = ~clk;
  end

  linear_blend_skinning dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(cur.opcode), .in_joint_index(cur.joint), .in_element_index(cur.elem),
    .in_load_value(cur.value),
    .in_pos_x(cur.pos[0]), .in_pos_y(cur.pos[1]), .in_pos_z(cur.pos[2]),
    .in_nrm_x(cur.nrm[0]), .in_nrm_y(cur.nrm[1]), .in_nrm_z(cur.nrm[2]),
    .in_bone_ids(cur.bones), .in_bone_weights(cur.weights),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos[0]), .out_pos_y(out_pos[1]), .out_pos_z(out_pos[2]),
    .out_nrm_x(out_nrm[0]), .out_nrm_y(out_nrm[1]), .out_nrm_z(out_nrm[2]),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fix_mul(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'(signed'(a)) * longint'(signed'(b)) + 64'sd32768;
    return p >>> FRAC_BITS;
  endfunction

  function automatic void build_palette(int j);
    longint acc;
    int b;
    b = j * MAT_WORDS;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ident) begin
          acc = (r == c) ? 64'sd65536 : 64'sd0;
        end else begin
          acc = (c == 3) ? longint'(signed'(pose_mem[b + r*4 + 3])) : 64'sd0;
          for (int k = 0; k < 3; k++)
            acc += fix_mul(pose_mem[b + r*4 + k], bind_mem[b + k*4 + c]);
          acc = clamp32(acc);
        end
        pal_mem[b + r*4 + c] = acc[31:0];
      end
    end
  endfunction

  function automatic vertex_t skin_vertex(request_t q);
    vertex_t v;
    longint acc [6];
    longint tp, tn, w;
    int bone, b;
    for (int r = 0; r < 6; r++) acc[r] = 0;
    for (int i = 0; i < INFLUENCES; i++) begin
      bone = q.bones[6*i +: 6];
      w = q.weights[16*i +: 16];
      if (w != 0 && bone < joints_used) begin
        b = bone * MAT_WORDS;
        for (int r = 0; r < 3; r++) begin
          tp = clamp32(fix_mul(pal_mem[b+r*4], q.pos[0]) + fix_mul(pal_mem[b+r*4+1], q.pos[1])
                     + fix_mul(pal_mem[b+r*4+2], q.pos[2])
                     + longint'(signed'(pal_mem[b+r*4+3])));
          tn = clamp32(fix_mul(pal_mem[b+r*4], q.nrm[0]) + fix_mul(pal_mem[b+r*4+1], q.nrm[1])
                     + fix_mul(pal_mem[b+r*4+2], q.nrm[2]));
          acc[r]   += (tp * w + 64'sd32768) >>> WEIGHT_BITS;
          acc[3+r] += (tn * w + 64'sd32768) >>> WEIGHT_BITS;
        end
      end
    end
    for (int r = 0; r < 3; r++) begin
      v.pos[r] = 32'(clamp32(acc[r]));
      v.nrm[r] = 32'(clamp32(acc[3+r]));
    end
    return v;
  endfunction

  function automatic void apply_request(request_t q);
    case (q.opcode)
      OP_LOAD_POSE: if (q.elem < MAT_WORDS) pose_mem[q.joint*MAT_WORDS + q.elem] = q.value;
      OP_LOAD_BIND: if (q.elem < MAT_WORDS) bind_mem[q.joint*MAT_WORDS + q.elem] = q.value;
      OP_BUILD:     build_palette(q.joint);
      default:      vertex_q.insert(vertex_q.size(), skin_vertex(q));
    endcase
  endfunction

  // Request side: accept at the rising edge, drive at the falling edge.
  always @(posedge clk) begin
    took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) apply_request(cur);
  end

  always @(negedge clk) begin
    if (!in_valid || took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0 && rst_n) begin
        cur <= pending_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= send_quiet ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $error("skinned vertex with no request waiting");
        errors++;
      end else begin
        e = vertex_q.pop_front();
        for (int r = 0; r < 3; r++) begin
          if (out_pos[r] !== e.pos[r]) begin
            $error("%s: expected %h, got %h", pos_names[r], e.pos[r], out_pos[r]);
            errors++;
          end
          if (out_nrm[r] !== e.nrm[r]) begin
            $error("%s: expected %h, got %h", nrm_names[r], e.nrm[r], out_nrm[r]);
            errors++;
          end
        end
      end
      results_seen++;
      if (results_seen % 50 == 0) recv_quiet <= ($urandom_range(0, 3) == 0);
      stall_left <= recv_quiet ? 0 : $urandom_range(0, 14);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= recv_quiet ? 1'b0 : ($urandom_range(0, 7) == 0);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic bit fully_loaded(int j);
    for (int k = 0; k < MAT_WORDS; k++)
      if (!pose_w[j][k] || !bind_w[j][k]) return 0;
    return 1;
  endfunction

  function automatic request_t noise_request(op_t op);
    request_t q;
    q.opcode = op;
    q.joint = $urandom; q.elem = $urandom_range(0, 11); q.value = pick_word();
    for (int k = 0; k < 3; k++) begin
      q.pos[k] = pick_word(); q.nrm[k] = pick_word();
    end
    q.bones = $urandom;
    q.weights = {$urandom, $urandom};
    return q;
  endfunction

  task automatic send(request_t q);
    // Drop any influence that would read a palette entry never built.
    if (q.opcode == OP_SKIN) begin
      for (int i = 0; i < INFLUENCES; i++)
        if (q.bones[6*i +: 6] < joints_used && !pal_ok[q.bones[6*i +: 6]])
          q.weights[16*i +: 16] = '0;
    end
    if (q.opcode == OP_LOAD_POSE && q.elem < MAT_WORDS) pose_w[q.joint][q.elem] = 1;
    if (q.opcode == OP_LOAD_BIND && q.elem < MAT_WORDS) bind_w[q.joint][q.elem] = 1;
    if (q.opcode == OP_BUILD) pal_ok[q.joint] = 1;
    pending_q.insert(pending_q.size(), q);
  endtask

  task automatic load_joint(int j);
    request_t q;
    for (int k = 0; k < MAT_WORDS; k++) begin
      q = noise_request(OP_LOAD_POSE); q.joint = j; q.elem = k; send(q);
      q = noise_request(OP_LOAD_BIND); q.joint = j; q.elem = k; send(q);
    end
    q = noise_request(OP_BUILD); q.joint = j; send(q);
  endtask

  task automatic random_request();
    request_t q;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      q = noise_request(OP_LOAD_POSE);
    end else if (pick < 40) begin
      q = noise_request(OP_LOAD_BIND);
    end else if (pick < 52) begin
      q = noise_request(OP_BUILD);
      if (!fully_loaded(q.joint)) q.joint = $urandom_range(0, 7);
    end else begin
      q = noise_request(OP_SKIN);
      if ($urandom_range(0, 3) != 0) begin
        // Mostly bones that are present, so most influences are taken.
        for (int i = 0; i < INFLUENCES; i++) q.bones[6*i +: 6] = $urandom_range(0, 9);
      end
    end
    if (q.opcode inside {OP_LOAD_POSE, OP_LOAD_BIND}) begin
      if ($urandom_range(0, 1)) q.joint = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) q.elem = $urandom_range(12, 15);
    end
    send(q);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_JOINT_COUNT) joints_used = val[6:0];
    else ident = val[0];
  endtask

  task automatic set_mode(int jc, bit id);
    wait_idle();
    cfg_write(REG_JOINT_COUNT, jc);
    cfg_write(REG_IDENTITY, id);
  endtask

  initial begin
    request_t q;
    int jc_list [6] = '{64, 0, 9, 64, 5, 1};
    bit id_list [6] = '{0, 0, 1, 1, 0, 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(64, 0);
    for (int j = 0; j < 8; j++) load_joint(j);
    load_joint(63);

    // Directed: extreme vertices, full and zero weights, ignored loads.
    q = noise_request(OP_SKIN);
    q.bones = {6'd63, 6'd2, 6'd1, 6'd0}; q.weights = '1;
    for (int k = 0; k < 3; k++) begin
      q.pos[k] = 32'h7fff_ffff; q.nrm[k] = 32'h8000_0000;
    end
    send(q);
    for (int k = 0; k < 3; k++) begin
      q.pos[k] = 32'h8000_0000; q.nrm[k] = 32'h7fff_ffff;
    end
    send(q);
    q.weights = '0; send(q);
    q = noise_request(OP_SKIN); q.bones = {6'd3, 6'd3, 6'd3, 6'd3};
    q.weights = 64'h0000_0000_0000_ffff; send(q);
    q.weights = 64'h0001_0000_0000_0000; send(q);
    q = noise_request(OP_LOAD_POSE); q.joint = 0; q.elem = 4'd15; send(q);
    q = noise_request(OP_LOAD_BIND); q.joint = 1; q.elem = 4'd12; send(q);
    q = noise_request(OP_BUILD); q.joint = 0; send(q);
    q = noise_request(OP_SKIN); q.bones = {6'd0, 6'd1, 6'd0, 6'd1}; send(q);

    for (int p = 0; p < 6; p++) begin
      set_mode(jc_list[p], id_list[p]);
      if (id_list[p]) begin
        q = noise_request(OP_BUILD); q.joint = 2; send(q);
      end
      for (int n = 0; n < 230; n++) begin
        if (n % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        random_request();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/lbs_pkg.sv
src/linear_blend_skinning.sv
src/lbs_checker.sv
tb/sv/tb_top.sv
